// ----- src/iolh_pkg.sv -----
package iolh_pkg;

	localparam int PEND_DEPTH = 1024;
	localparam int STAT_DEPTH = 256;
	localparam int BUCKETS    = 16;
	localparam int PAW        = $clog2(PEND_DEPTH);
	localparam int SAW        = $clog2(STAT_DEPTH);
	localparam int BW         = $clog2(BUCKETS);
	localparam int BKW        = SAW + BW;
	localparam int CNT_W      = ((PAW > SAW) ? PAW : SAW) + 1;
	localparam longint unsigned NS_PER_US = 1000;

	localparam logic [1:0] OP_ISSUE    = 2'd0;
	localparam logic [1:0] OP_COMPLETE = 2'd1;
	localparam logic [1:0] OP_READ     = 2'd2;
	localparam logic [1:0] OP_UNUSED   = 2'd3;

	localparam logic [2:0] ST_ISSUED     = 3'd0;
	localparam logic [2:0] ST_ISSUE_FULL = 3'd1;
	localparam logic [2:0] ST_UNMATCHED  = 3'd2;
	localparam logic [2:0] ST_DISCARDED  = 3'd3;
	localparam logic [2:0] ST_RECORDED   = 3'd4;
	localparam logic [2:0] ST_STATS_FULL = 3'd5;
	localparam logic [2:0] ST_READ_HIT   = 3'd6;
	localparam logic [2:0] ST_READ_MISS  = 3'd7;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_PSCAN, S_PDECIDE, S_LAT, S_SSCAN,
		S_SDECIDE, S_BCLR, S_BINC, S_RDOUT
	} fsm_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] device;
		logic [63:0] sector;
		logic [31:0] owner;
		logic [63:0] start;
	} pend_row_t;

	typedef struct packed {
		logic [31:0] owner;
		logic [63:0] total;
		logic [63:0] maxv;
		logic [31:0] cnt;
		logic [31:0] device;
	} stat_row_t;

	// floor(log2(lat/1000)) capped: lat/1000 >= 2^k exactly when lat >= 1000*2^k
	function automatic logic [BW-1:0] bucket_of(input logic [63:0] lat);
		logic [BW-1:0] b;
		b = '0;
		for (int k = 1; k < BUCKETS; k++) begin
			if (lat >= (64'(NS_PER_US) << k))
				b = BW'(k);
		end
		return b;
	endfunction

endpackage

// ----- src/iolh_pend_mem.sv -----
module iolh_pend_mem import iolh_pkg::*; (
	input  logic            clk,
	input  logic            we,
	input  logic [PAW-1:0]  waddr,
	input  pend_row_t       wdata,
	input  logic [PAW-1:0]  raddr,
	output pend_row_t       rdata
);
	pend_row_t mem [PEND_DEPTH];
	pend_row_t rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ----- src/iolh_stat_mem.sv -----
module iolh_stat_mem import iolh_pkg::*; (
	input  logic            clk,
	input  logic            we,
	input  logic [SAW-1:0]  waddr,
	input  stat_row_t       wdata,
	input  logic [SAW-1:0]  raddr,
	output stat_row_t       rdata
);
	stat_row_t mem [STAT_DEPTH];
	stat_row_t rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ----- src/iolh_bkt_mem.sv -----
module iolh_bkt_mem import iolh_pkg::*; (
	input  logic            clk,
	input  logic            we,
	input  logic [BKW-1:0]  waddr,
	input  logic [31:0]     wdata,
	input  logic [BKW-1:0]  raddr,
	output logic [31:0]     rdata
);
	logic [31:0] mem [STAT_DEPTH*BUCKETS];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ----- src/io_latency_histogram_tracker_top.sv -----
// Each item runs one-entry-per-cycle sweeps: issue and complete sweep the in-flight table,
//   read sweeps the stats table, and a recorded completion also sweeps the stats table and
//   then clears the new row's buckets, setting its own to one, or increments one bucket.
// Throughput: one item at a time; busy falls with the result beat, which ends the item.
// Reset: arst_n clears control and valid bits, then a clearing pass over every entry
//   zeroes the in-flight table with busy high. The receiver cannot stall.
module io_latency_histogram_tracker_top import iolh_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  logic [1:0]   operation,
	input  logic [31:0]  device,
	input  logic [63:0]  sector,
	input  logic [31:0]  requester,
	input  logic [63:0]  time_ns,
	input  logic [3:0]   bucket_select,
	output logic         done,
	output logic [2:0]   status,
	output logic [31:0]  owner,
	output logic [63:0]  latency_ns,
	output logic [3:0]   bucket,
	output logic [31:0]  count,
	output logic [63:0]  sum_ns,
	output logic [63:0]  max_ns,
	output logic [31:0]  first_device,
	output logic [31:0]  bucket_count
);
	fsm_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;

	// captured input beat
	logic [1:0]  op_q;
	logic [31:0] dev_q, req_q;
	logic [63:0] sec_q, time_q;
	logic [3:0]  sel_q;

	// sweep bookkeeping
	logic             rd_en_s1;
	logic [CNT_W-1:0] idx_s1;
	logic             hit_q, free_q;
	logic [CNT_W-1:0] hit_idx_q, free_idx_q;
	logic [31:0]      powner_q;
	logic [63:0]      pstart_q, lat_q;
	logic [BW-1:0]    bkt_q;
	stat_row_t        srow_q;
	logic [STAT_DEPTH-1:0] sv_q;

	// memory ports
	logic            pend_we;
	logic [PAW-1:0]  pend_waddr, pend_raddr;
	pend_row_t       pend_wdata, pend_rdata;
	logic            stat_we;
	logic [SAW-1:0]  stat_waddr, stat_raddr;
	stat_row_t       stat_wdata, stat_rdata, nrow;
	logic            bkt_we;
	logic [BKW-1:0]  bkt_waddr, bkt_raddr;
	logic [31:0]     bkt_wdata, bkt_rdata;

	// result beat staging
	logic        res_ld;
	logic [2:0]  res_status;
	logic [31:0] res_owner, res_count, res_device, res_bcount;
	logic [63:0] res_lat, res_total, res_max;
	logic [3:0]  res_bucket;

	logic        pscan_end, sscan_end, discard;
	logic [31:0] skey;

	iolh_pend_mem u_pend (
		.clk(clk), .we(pend_we), .waddr(pend_waddr), .wdata(pend_wdata),
		.raddr(pend_raddr), .rdata(pend_rdata)
	);

	iolh_stat_mem u_stat (
		.clk(clk), .we(stat_we), .waddr(stat_waddr), .wdata(stat_wdata),
		.raddr(stat_raddr), .rdata(stat_rdata)
	);

	iolh_bkt_mem u_bkt (
		.clk(clk), .we(bkt_we), .waddr(bkt_waddr), .wdata(bkt_wdata),
		.raddr(bkt_raddr), .rdata(bkt_rdata)
	);

	assign pscan_end = (cnt_q == CNT_W'(PEND_DEPTH)) && !rd_en_s1;
	assign sscan_end = (cnt_q == CNT_W'(STAT_DEPTH)) && !rd_en_s1;
	assign discard   = (lat_q == 64'd0) || (powner_q == 32'd0);
	assign skey      = (op_q == OP_READ) ? req_q : powner_q;
	assign busy      = (state_q != S_IDLE);

	// Updated stats row: either a fresh entry or the old one plus this latency.
	always_comb begin
		if (hit_q) begin
			nrow.owner  = srow_q.owner;
			nrow.total  = srow_q.total + lat_q;
			nrow.maxv   = (lat_q > srow_q.maxv) ? lat_q : srow_q.maxv;
			nrow.cnt    = srow_q.cnt + 32'd1;
			nrow.device = srow_q.device;
		end else begin
			nrow.owner  = powner_q;
			nrow.total  = lat_q;
			nrow.maxv   = lat_q;
			nrow.cnt    = 32'd1;
			nrow.device = dev_q;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:
				if (cnt_q == CNT_W'(PEND_DEPTH - 1)) state_d = S_IDLE;
			S_IDLE:
				if (start) begin
					unique case (operation)
						OP_ISSUE, OP_COMPLETE: state_d = S_PSCAN;
						OP_READ:               state_d = S_SSCAN;
						default:               state_d = S_IDLE;
					endcase
				end
			S_PSCAN:
				if (pscan_end) state_d = S_PDECIDE;
			S_PDECIDE:
				state_d = (op_q == OP_COMPLETE && hit_q) ? S_LAT : S_IDLE;
			S_LAT:
				state_d = discard ? S_IDLE : S_SSCAN;
			S_SSCAN:
				if (sscan_end) state_d = S_SDECIDE;
			S_SDECIDE:
				if (op_q == OP_READ)
					state_d = hit_q ? S_RDOUT : S_IDLE;
				else if (hit_q)
					state_d = S_BINC;
				else if (free_q)
					state_d = S_BCLR;
				else
					state_d = S_IDLE;
			S_BCLR:
				if (cnt_q == CNT_W'(BUCKETS - 1)) state_d = S_IDLE;
			S_BINC:  state_d = S_IDLE;
			S_RDOUT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Memory controls and result beat.
	always_comb begin
		pend_we    = 1'b0;
		pend_waddr = cnt_q[PAW-1:0];
		pend_wdata = '0;
		pend_raddr = cnt_q[PAW-1:0];
		stat_we    = 1'b0;
		stat_waddr = hit_q ? hit_idx_q[SAW-1:0] : free_idx_q[SAW-1:0];
		stat_wdata = nrow;
		stat_raddr = cnt_q[SAW-1:0];
		bkt_we     = 1'b0;
		bkt_waddr  = {free_idx_q[SAW-1:0], cnt_q[BW-1:0]};
		bkt_wdata  = (cnt_q[BW-1:0] == bkt_q) ? 32'd1 : 32'd0;
		bkt_raddr  = {hit_idx_q[SAW-1:0], bkt_q};
		res_ld     = 1'b0;
		res_status = ST_ISSUED;
		res_owner  = '0;
		res_lat    = '0;
		res_bucket = '0;
		res_count  = '0;
		res_total  = '0;
		res_max    = '0;
		res_device = '0;
		res_bcount = '0;
		unique case (state_q)
			S_CLEAR: pend_we = 1'b1;
			S_PDECIDE: begin
				pend_waddr = hit_q ? hit_idx_q[PAW-1:0] : free_idx_q[PAW-1:0];
				if (op_q == OP_ISSUE) begin
					res_ld    = 1'b1;
					res_owner = req_q;
					if (hit_q || free_q) begin
						pend_we    = 1'b1;
						pend_wdata = '{valid: 1'b1, device: dev_q, sector: sec_q,
							owner: req_q, start: time_q};
						res_status = ST_ISSUED;
					end else begin
						res_status = ST_ISSUE_FULL;
					end
				end else if (!hit_q) begin
					res_ld     = 1'b1;
					res_status = ST_UNMATCHED;
				end else begin
					// drop the in-flight entry
					pend_we = 1'b1;
				end
			end
			S_LAT:
				if (discard) begin
					res_ld     = 1'b1;
					res_status = ST_DISCARDED;
					res_owner  = powner_q;
					res_lat    = lat_q;
				end
			S_SDECIDE:
				if (op_q == OP_READ) begin
					bkt_raddr = {hit_idx_q[SAW-1:0], sel_q[BW-1:0]};
					if (!hit_q) begin
						res_ld     = 1'b1;
						res_status = ST_READ_MISS;
						res_owner  = req_q;
					end
				end else if (!hit_q && !free_q) begin
					res_ld     = 1'b1;
					res_status = ST_STATS_FULL;
					res_owner  = powner_q;
					res_lat    = lat_q;
					res_bucket = 4'(bkt_q);
				end else begin
					stat_we = 1'b1;
				end
			S_BCLR, S_BINC: begin
				if (state_q == S_BCLR) begin
					bkt_we = 1'b1;
				end else begin
					bkt_we    = 1'b1;
					bkt_waddr = {hit_idx_q[SAW-1:0], bkt_q};
					bkt_wdata = bkt_rdata + 32'd1;
				end
				res_ld     = (state_q == S_BINC) || (cnt_q == CNT_W'(BUCKETS - 1));
				res_status = ST_RECORDED;
				res_owner  = powner_q;
				res_lat    = lat_q;
				res_bucket = 4'(bkt_q);
				res_count  = srow_q.cnt;
				res_total  = srow_q.total;
				res_max    = srow_q.maxv;
				res_device = srow_q.device;
			end
			S_RDOUT: begin
				res_ld     = 1'b1;
				res_status = ST_READ_HIT;
				res_owner  = req_q;
				res_bucket = sel_q;
				res_count  = srow_q.cnt;
				res_total  = srow_q.total;
				res_max    = srow_q.maxv;
				res_device = srow_q.device;
				res_bcount = bkt_rdata;
			end
			default: ;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			cnt_q    <= '0;
			rd_en_s1 <= 1'b0;
			hit_q    <= 1'b0;
			free_q   <= 1'b0;
			sv_q     <= '0;
			done     <= 1'b0;
		end else begin
			state_q  <= state_d;
			done     <= res_ld;
			rd_en_s1 <= ((state_q == S_PSCAN) && (cnt_q < CNT_W'(PEND_DEPTH))) ||
				((state_q == S_SSCAN) && (cnt_q < CNT_W'(STAT_DEPTH)));
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else if (state_q == S_CLEAR || state_q == S_BCLR ||
				(state_q == S_PSCAN && cnt_q < CNT_W'(PEND_DEPTH)) ||
				(state_q == S_SSCAN && cnt_q < CNT_W'(STAT_DEPTH))) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if ((state_d == S_PSCAN || state_d == S_SSCAN) && state_d != state_q) begin
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (rd_en_s1 && state_q == S_PSCAN) begin
				if (pend_rdata.valid) begin
					if (!hit_q && pend_rdata.device == dev_q &&
						pend_rdata.sector == sec_q) begin
						hit_q <= 1'b1;
					end
				end else if (!free_q) begin
					free_q <= 1'b1;
				end
			end else if (rd_en_s1 && state_q == S_SSCAN) begin
				if (sv_q[idx_s1[SAW-1:0]]) begin
					if (!hit_q && stat_rdata.owner == skey)
						hit_q <= 1'b1;
				end else if (!free_q) begin
					free_q <= 1'b1;
				end
			end
			if (state_q == S_SDECIDE && op_q == OP_COMPLETE && !hit_q && free_q)
				sv_q[free_idx_q[SAW-1:0]] <= 1'b1;
		end
	end

	// Payload: input capture, sweep results, latency and bucket.
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (state_q == S_IDLE && start) begin
			op_q   <= operation;
			dev_q  <= device;
			sec_q  <= sector;
			req_q  <= requester;
			time_q <= time_ns;
			sel_q  <= bucket_select;
		end
		if (rd_en_s1 && state_q == S_PSCAN) begin
			if (pend_rdata.valid) begin
				if (!hit_q && pend_rdata.device == dev_q && pend_rdata.sector == sec_q) begin
					hit_idx_q <= idx_s1;
					powner_q  <= pend_rdata.owner;
					pstart_q  <= pend_rdata.start;
				end
			end else if (!free_q) begin
				free_idx_q <= idx_s1;
			end
		end
		if (rd_en_s1 && state_q == S_SSCAN) begin
			if (sv_q[idx_s1[SAW-1:0]]) begin
				if (!hit_q && stat_rdata.owner == skey) begin
					hit_idx_q <= idx_s1;
					srow_q    <= stat_rdata;
				end
			end else if (!free_q) begin
				free_idx_q <= idx_s1;
			end
		end
		if (state_q == S_PDECIDE)
			lat_q <= time_q - pstart_q;
		if (state_q == S_LAT)
			bkt_q <= bucket_of(lat_q);
		if (state_q == S_SDECIDE && op_q == OP_COMPLETE)
			srow_q <= nrow;
		if (res_ld) begin
			status       <= res_status;
			owner        <= res_owner;
			latency_ns   <= res_lat;
			bucket       <= res_bucket;
			count        <= res_count;
			sum_ns       <= res_total;
			max_ns       <= res_max;
			first_device <= res_device;
			bucket_count <= res_bcount;
		end
	end
endmodule

// ----- src/iolh_checker.sv -----
module iolh_checker import iolh_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  operation,
	input logic        done,
	input logic [2:0]  status,
	input logic [31:0] owner,
	input logic [63:0] latency_ns,
	input logic [3:0]  bucket,
	input logic [31:0] count
);
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result beat longer than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result beat while still busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation != OP_UNUSED) |=> busy)
		else $error("accepted item did not raise busy");

	a_unmatched: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_UNMATCHED) |-> (owner == 32'd0 && latency_ns == 64'd0))
		else $error("unmatched completion carries data");

	a_read_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_READ_MISS) |-> (count == 32'd0 && bucket == 4'd0))
		else $error("read miss carries stats");
endmodule

bind io_latency_histogram_tracker_top iolh_checker u_iolh_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .operation(operation),
	.done(done), .status(status), .owner(owner), .latency_ns(latency_ns),
	.bucket(bucket), .count(count)
);

// ----- sim/io_latency_histogram_tracker_top_tb.sv -----
module io_latency_histogram_tracker_top_tb;
	import iolh_pkg::*;

	localparam longint unsigned CYCLE_LIMIT = 20_000_000;
	localparam int RANDOM_ITEMS = 60;

	// Field slots of one result beat, in port order.
	localparam int F_STATUS  = 0;
	localparam int F_OWNER   = 1;
	localparam int F_LAT     = 2;
	localparam int F_BUCKET  = 3;
	localparam int F_COUNT   = 4;
	localparam int F_TOTAL   = 5;
	localparam int F_MAX     = 6;
	localparam int F_DEVICE  = 7;
	localparam int F_BKCOUNT = 8;
	localparam int NFIELDS   = 9;

	typedef logic [NFIELDS-1:0][63:0] beat_t;

	// Scoreboard: mirrors the in-flight and per-requester tables, queues the
	// beat that each accepted item must produce and checks beats in order.
	class latency_scoreboard;
		bit          pend_v [PEND_DEPTH];
		logic [31:0] pend_dev [PEND_DEPTH];
		logic [63:0] pend_sec [PEND_DEPTH];
		logic [31:0] pend_own [PEND_DEPTH];
		logic [63:0] pend_t0 [PEND_DEPTH];
		bit          stat_v [STAT_DEPTH];
		logic [31:0] stat_own [STAT_DEPTH];
		logic [63:0] stat_tot [STAT_DEPTH];
		logic [63:0] stat_max [STAT_DEPTH];
		logic [31:0] stat_cnt [STAT_DEPTH];
		logic [31:0] stat_dev [STAT_DEPTH];
		logic [31:0] stat_hist [STAT_DEPTH][BUCKETS];
		beat_t       expected_beats [$];
		int          errors;
		int          pend_used;
		int          seen [8];

		function int find_inflight(logic [31:0] dev, logic [63:0] sec, output int free_slot);
			free_slot = -1;
			for (int i = 0; i < PEND_DEPTH; i++) begin
				if (pend_v[i]) begin
					if (pend_dev[i] == dev && pend_sec[i] == sec) return i;
				end else if (free_slot < 0) begin
					free_slot = i;
				end
			end
			return -1;
		endfunction

		function int find_requester(logic [31:0] id, output int free_slot);
			free_slot = -1;
			for (int i = 0; i < STAT_DEPTH; i++) begin
				if (stat_v[i]) begin
					if (stat_own[i] == id) return i;
				end else if (free_slot < 0) begin
					free_slot = i;
				end
			end
			return -1;
		endfunction

		function logic [3:0] log2_us_bucket(logic [63:0] lat);
			logic [63:0] us;
			int b;
			us = lat / 64'd1000;
			b = 0;
			while (us > 1 && b < BUCKETS - 1) begin
				us = us >> 1;
				b++;
			end
			return 4'(b);
		endfunction

		// Note one accepted input beat and queue the beat it must produce.
		function void note_item(logic [1:0] op, logic [31:0] dev, logic [63:0] sec,
				logic [31:0] req, logic [63:0] now, logic [3:0] sel);
			beat_t b;
			int hit, fr, sh, sfr;
			logic [63:0] lat;
			logic [31:0] who;
			logic [3:0] bk;
			if (op == OP_UNUSED) return;
			b = '0;
			case (op)
				OP_ISSUE: begin
					b[F_OWNER] = req;
					hit = find_inflight(dev, sec, fr);
					if (hit < 0) hit = fr;
					if (hit < 0) begin
						b[F_STATUS] = ST_ISSUE_FULL;
					end else begin
						if (!pend_v[hit]) pend_used++;
						pend_v[hit] = 1;
						pend_dev[hit] = dev;
						pend_sec[hit] = sec;
						pend_own[hit] = req;
						pend_t0[hit] = now;
						b[F_STATUS] = ST_ISSUED;
					end
				end
				OP_COMPLETE: begin
					hit = find_inflight(dev, sec, fr);
					if (hit < 0) begin
						b[F_STATUS] = ST_UNMATCHED;
					end else begin
						lat = now - pend_t0[hit];
						who = pend_own[hit];
						pend_v[hit] = 0;
						pend_used--;
						b[F_OWNER] = who;
						b[F_LAT] = lat;
						if (lat == 0 || who == 0) begin
							b[F_STATUS] = ST_DISCARDED;
						end else begin
							bk = log2_us_bucket(lat);
							b[F_BUCKET] = bk;
							sh = find_requester(who, sfr);
							if (sh < 0 && sfr < 0) begin
								b[F_STATUS] = ST_STATS_FULL;
							end else begin
								if (sh < 0) begin
									sh = sfr;
									stat_v[sh] = 1;
									stat_own[sh] = who;
									stat_tot[sh] = 0;
									stat_max[sh] = 0;
									stat_cnt[sh] = 0;
									stat_dev[sh] = dev;
									for (int k = 0; k < BUCKETS; k++) stat_hist[sh][k] = 0;
								end
								stat_tot[sh] += lat;
								stat_cnt[sh] += 1;
								stat_hist[sh][bk] += 1;
								if (lat > stat_max[sh]) stat_max[sh] = lat;
								b[F_STATUS] = ST_RECORDED;
								b[F_COUNT] = stat_cnt[sh];
								b[F_TOTAL] = stat_tot[sh];
								b[F_MAX] = stat_max[sh];
								b[F_DEVICE] = stat_dev[sh];
							end
						end
					end
				end
				default: begin
					b[F_OWNER] = req;
					sh = find_requester(req, sfr);
					if (sh < 0) begin
						b[F_STATUS] = ST_READ_MISS;
					end else begin
						b[F_STATUS] = ST_READ_HIT;
						b[F_BUCKET] = sel;
						b[F_COUNT] = stat_cnt[sh];
						b[F_TOTAL] = stat_tot[sh];
						b[F_MAX] = stat_max[sh];
						b[F_DEVICE] = stat_dev[sh];
						if (sel < BUCKETS) b[F_BKCOUNT] = stat_hist[sh][sel];
					end
				end
			endcase
			expected_beats.push_back(b);
		endfunction

		function void check_beat(beat_t got);
			beat_t want;
			string names [NFIELDS];
			names = '{"status", "owner", "latency_ns", "bucket", "count", "sum_ns",
				"max_ns", "first_device", "bucket_count"};
			seen[got[F_STATUS][2:0]]++;
			if (expected_beats.size() == 0) begin
				$display("%0t: unexpected result beat, status %0d", $time, got[F_STATUS]);
				errors++;
				return;
			end
			want = expected_beats.pop_front();
			for (int f = 0; f < NFIELDS; f++) begin
				if (got[f] !== want[f]) begin
					$display("%0t: %s mismatch, expected %0h, actual %0h", $time, names[f],
						want[f], got[f]);
					errors++;
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  operation;
	logic [31:0] device;
	logic [63:0] sector;
	logic [31:0] requester;
	logic [63:0] time_ns;
	logic [3:0]  bucket_select;
	logic        done;
	logic [2:0]  status;
	logic [31:0] owner;
	logic [63:0] latency_ns;
	logic [3:0]  bucket;
	logic [31:0] count;
	logic [63:0] sum_ns;
	logic [63:0] max_ns;
	logic [31:0] first_device;
	logic [31:0] bucket_count;

	io_latency_histogram_tracker_top DUT (.*);

	latency_scoreboard sb = new();
	longint unsigned cycles = 0;
	bit quiet_sender = 0;    // when set, the sender never gaps

	// Stimulus bookkeeping: keys believed in flight, and requesters used so far.
	logic [31:0] key_dev [$];
	logic [63:0] key_sec [$];
	logic [63:0] key_t0 [$];
	logic [31:0] known_ids [$];

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Count cycles and bail out if the block hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Sample result beats at the rising edge; done marks a one-cycle beat.
	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_beat({64'(bucket_count), 64'(first_device), max_ns, sum_ns,
				64'(count), 64'(bucket), latency_ns, 64'(owner), 64'(status)});
		end
	end

	// Drive one command beat. Called and returns at a falling edge; start stays
	// high on return so a back-to-back item keeps it high without a glitch.
	task automatic send(input logic [1:0] op, input logic [31:0] dev, input logic [63:0] sec,
			input logic [31:0] req, input logic [63:0] now, input logic [3:0] sel);
		int gap;
		gap = quiet_sender ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13));
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		operation = op;
		device = dev;
		sector = sec;
		requester = req;
		time_ns = now;
		bucket_select = sel;
		start = 1'b1;
		// busy only moves at a rising edge, so its value here decides the next edge
		while (busy !== 1'b0) @(negedge clk);
		sb.note_item(op, dev, sec, req, now, sel);
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Latency spread over every bucket, with zero and wrapping values mixed in.
	function automatic logic [63:0] pick_latency();
		int k;
		case ($urandom_range(0, 11))
			0: return 64'd0;
			1: return rand64();
			default: begin
				k = $urandom_range(0, 17);
				return (64'd1000 << k) + 64'($urandom_range(0, 1000 << k));
			end
		endcase
	endfunction

	function automatic logic [31:0] pick_owner();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4) return 32'd0;
		if (r < 22 && known_ids.size() > 0) return known_ids[$urandom_range(0, known_ids.size() - 1)];
		known_ids.push_back($urandom | 32'd1);
		return known_ids[$];
	endfunction

	task automatic issue_random();
		int i;
		logic [63:0] t0;
		t0 = rand64();
		if (key_dev.size() > 0 && $urandom_range(0, 9) == 0) begin
			// overwrite a key that is already in flight
			i = $urandom_range(0, key_dev.size() - 1);
			key_t0[i] = t0;
			send(OP_ISSUE, key_dev[i], key_sec[i], pick_owner(), t0, 4'($urandom));
		end else begin
			key_dev.push_back($urandom);
			key_sec.push_back(rand64());
			key_t0.push_back(t0);
			send(OP_ISSUE, key_dev[$], key_sec[$], pick_owner(), t0, 4'($urandom));
		end
	endtask

	task automatic complete_random();
		int i;
		logic [31:0] dv;
		logic [63:0] sc, t0;
		if (key_dev.size() == 0 || $urandom_range(0, 9) == 0) begin
			send(OP_COMPLETE, $urandom, rand64(), $urandom, rand64(), 4'($urandom));
		end else begin
			i = $urandom_range(0, key_dev.size() - 1);
			dv = key_dev[i];
			sc = key_sec[i];
			t0 = key_t0[i];
			key_dev.delete(i);
			key_sec.delete(i);
			key_t0.delete(i);
			send(OP_COMPLETE, dv, sc, $urandom, t0 + pick_latency(), 4'($urandom));
		end
	endtask

	task automatic read_random();
		logic [31:0] id;
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) id = 32'd0;
		else if (r == 1 || known_ids.size() == 0) id = $urandom;
		else id = known_ids[$urandom_range(0, known_ids.size() - 1)];
		send(OP_READ, $urandom, rand64(), id, rand64(), 4'($urandom));
	endtask

	initial begin
		int r;
		int fill_extra;
		logic [63:0] max64;
		max64 = '1;
		// Hold every input at a known value through reset.
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_ISSUE;
		device = '0;
		sector = '0;
		requester = '0;
		time_ns = '0;
		bucket_select = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed: zero latency, zero requester, unmatched, overwrite, wrap,
		// every bucket extreme, read hit and miss, id zero read, unused opcode.
		send(OP_ISSUE, 32'd0, 64'd0, 32'd5, 64'd0, 4'd0);
		send(OP_COMPLETE, 32'd0, 64'd0, 32'd0, 64'd0, 4'd0);
		send(OP_ISSUE, '1, max64, '1, 64'd100, 4'd15);
		send(OP_COMPLETE, '1, max64, '1, 64'd1099, 4'd15);
		send(OP_ISSUE, 32'd7, 64'd7, 32'd0, 64'd10, 4'd0);
		send(OP_COMPLETE, 32'd7, 64'd7, 32'd0, 64'd5000, 4'd0);
		send(OP_COMPLETE, 32'd8, 64'd8, 32'd9, 64'd5000, 4'd0);
		send(OP_ISSUE, 32'd3, 64'd3, 32'd11, 64'd0, 4'd0);
		send(OP_ISSUE, 32'd3, 64'd3, 32'd12, 64'd1000, 4'd0);
		send(OP_COMPLETE, 32'd3, 64'd3, 32'd0, 64'd3000, 4'd0);
		send(OP_ISSUE, 32'd4, 64'd4, '1, max64, 4'd0);
		send(OP_COMPLETE, 32'd4, 64'd4, 32'd0, 64'd5, 4'd0);
		send(OP_ISSUE, 32'd5, 64'd5, '1, 64'd0, 4'd0);
		send(OP_COMPLETE, 32'd5, 64'd5, 32'd0, max64, 4'd0);
		send(OP_ISSUE, 32'd6, 64'd6, 32'd12, 64'd0, 4'd0);
		send(OP_COMPLETE, 32'd6, 64'd6, 32'd0, 64'd2000, 4'd0);
		send(OP_READ, 32'd0, 64'd0, '1, 64'd0, 4'd0);
		send(OP_READ, 32'd0, 64'd0, '1, 64'd0, 4'd15);
		send(OP_READ, 32'd0, 64'd0, 32'd12, 64'd0, 4'd1);
		send(OP_READ, 32'd0, 64'd0, 32'd12, 64'd0, 4'd2);
		send(OP_READ, 32'd0, 64'd0, 32'd99, 64'd0, 4'd3);
		send(OP_READ, 32'd0, 64'd0, 32'd0, 64'd0, 4'd0);
		send(OP_UNUSED, '1, max64, '1, max64, 4'd15);
		send(OP_READ, 32'd0, 64'd0, 32'd5, 64'd0, 4'd0);

		// Random: a short mix of issue/complete pairs with reads and stray
		// opcodes; the table fill below carries most of the items.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 60 == 0) quiet_sender = ($urandom_range(0, 2) == 0);
			r = $urandom_range(0, 99);
			if (r < 42) issue_random();
			else if (r < 87) complete_random();
			else if (r < 97) read_random();
			else send(OP_UNUSED, $urandom, rand64(), $urandom, rand64(), 4'($urandom));
		end
		quiet_sender = 0;

		// Drain: hold off until every queued result has come back.
		start = 1'b0;
		while (sb.expected_beats.size() != 0) @(negedge clk);

		// Fill the in-flight table with fresh keys, then push past it.
		fill_extra = 0;
		for (int n = 0; fill_extra < 3; n++) begin
			if (sb.pend_used == PEND_DEPTH) fill_extra++;
			send(OP_ISSUE, $urandom, {32'hF111_0000, 32'(n)}, pick_owner(), rand64(), 4'($urandom));
		end
		// Completing a tracked key frees a slot, unless a stray key is picked; a new key must land there.
		complete_random();
		send(OP_ISSUE, $urandom, rand64(), pick_owner(), rand64(), 4'($urandom));
		send(OP_ISSUE, $urandom, rand64(), pick_owner(), rand64(), 4'($urandom));
		start = 1'b0;

		while (sb.expected_beats.size() != 0) @(negedge clk);
		repeat (2 * PEND_DEPTH + STAT_DEPTH + 40) @(negedge clk);

		$display("Covered: issued %0d, issue full %0d, unmatched %0d, discarded %0d,",
			sb.seen[ST_ISSUED], sb.seen[ST_ISSUE_FULL], sb.seen[ST_UNMATCHED],
			sb.seen[ST_DISCARDED]);
		$display("  recorded %0d, stats full %0d, read hit %0d, read miss %0d beats",
			sb.seen[ST_RECORDED], sb.seen[ST_STATS_FULL], sb.seen[ST_READ_HIT],
			sb.seen[ST_READ_MISS]);
		if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
